@@ rtl/gbs_pkg.sv @@
// ----------------------------------------------------------------------------
// gbs_pkg
// Shared types and constants for the greedy box suppression core.
// ----------------------------------------------------------------------------
package gbs_pkg;

    localparam int MAX_KEPT_DEF = 64;
    localparam int COORD_W      = 16;
    localparam int THR_W        = 8;
    localparam int SLOT_W       = 7;
    localparam logic [THR_W-1:0] IOU_THR_RESET = 8'd102;

    typedef struct packed {
        logic signed [COORD_W-1:0] left;
        logic signed [COORD_W-1:0] top;
        logic        [COORD_W-1:0] width;
        logic        [COORD_W-1:0] height;
    } box_t;

    localparam int BOX_W = $bits(box_t);

    typedef struct packed {
        logic busy;
        logic hit_valid;
        logic hit;
    } iou_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

endpackage

@@ rtl/gbs_ram.sv @@
// ----------------------------------------------------------------------------
// gbs_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module gbs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                          aclk,
    input  logic                                          wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
    input  logic [WIDTH-1:0]                              wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
    output logic [WIDTH-1:0]                              rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/gbs_iou.sv @@
// ----------------------------------------------------------------------------
// gbs_iou
// Pipelined overlap test: one stored box per cycle against the current box.
// Flags a hit when intersection * 256 > threshold * union. Five stages.
// ----------------------------------------------------------------------------
module gbs_iou (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          entry_valid,
    input  gbs_pkg::box_t                 entry,
    input  gbs_pkg::box_t                 cur,
    input  logic [gbs_pkg::THR_W-1:0]     thr,
    output gbs_pkg::iou_status_t          status
);

    function automatic logic [gbs_pkg::COORD_W-1:0] overlap_len(
        input logic signed [gbs_pkg::COORD_W-1:0] a0,
        input logic        [gbs_pkg::COORD_W-1:0] alen,
        input logic signed [gbs_pkg::COORD_W-1:0] b0,
        input logic        [gbs_pkg::COORD_W-1:0] blen
    );
        logic signed [gbs_pkg::COORD_W+1:0] s0, e0, s1, e1, lo, hi, d;
        s0 = (gbs_pkg::COORD_W+2)'(a0);
        s1 = (gbs_pkg::COORD_W+2)'(b0);
        e0 = s0 + $signed({2'b00, alen});
        e1 = s1 + $signed({2'b00, blen});
        lo = (s0 > s1) ? s0 : s1;
        hi = (e0 < e1) ? e0 : e1;
        d  = hi - lo;
        return (hi > lo) ? d[gbs_pkg::COORD_W-1:0] : '0;
    endfunction

    localparam int CW   = gbs_pkg::COORD_W;
    localparam int AR_W = 2 * CW;
    localparam int UN_W = AR_W + 1;
    localparam int PR_W = UN_W + gbs_pkg::THR_W;

    logic [4:0]      v_reg;
    logic [CW-1:0]   ox_reg, oy_reg, bw_reg, bh_reg;
    logic [AR_W-1:0] inter2_reg, area_a_reg, area_b_reg;
    logic [AR_W-1:0] inter3_reg;
    logic [UN_W-1:0] uni_reg;
    logic [PR_W-1:0] lhs_reg, prod_reg;
    logic            hit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= {v_reg[3:0], entry_valid};
        end
    end

    always_ff @(posedge aclk) begin
        ox_reg     <= overlap_len(cur.left, cur.width, entry.left, entry.width);
        oy_reg     <= overlap_len(cur.top, cur.height, entry.top, entry.height);
        bw_reg     <= entry.width;
        bh_reg     <= entry.height;
        inter2_reg <= AR_W'(ox_reg) * AR_W'(oy_reg);
        area_b_reg <= AR_W'(bw_reg) * AR_W'(bh_reg);
        area_a_reg <= AR_W'(cur.width) * AR_W'(cur.height);
        uni_reg    <= UN_W'(area_a_reg) + UN_W'(area_b_reg) - UN_W'(inter2_reg);
        inter3_reg <= inter2_reg;
        lhs_reg    <= PR_W'({inter3_reg, 8'b0});
        prod_reg   <= PR_W'(thr) * PR_W'(uni_reg);
        hit_reg    <= lhs_reg > prod_reg;
    end

    assign status.busy      = |v_reg;
    assign status.hit_valid = v_reg[4];
    assign status.hit       = hit_reg;

endmodule

@@ rtl/greedy_box_suppression_core.sv @@
// ----------------------------------------------------------------------------
// greedy_box_suppression_core
// Greedy IoU suppression over boxes arriving in falling score order.
// Each input box is compared against every box stored in the frame (at most MAX_KEPT),
// one stored box per cycle, and its verdict is registered for the output.
// A new box is accepted only while idle, after the last box has its verdict; the
// next box is taken while a result waits.
// Reset: kept list empty, threshold 102; box memory is not initialized.
// ----------------------------------------------------------------------------
module greedy_box_suppression_core #(
    parameter int MAX_KEPT = gbs_pkg::MAX_KEPT_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [gbs_pkg::THR_W-1:0]            cfg_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_frame_start,
    input  logic signed [gbs_pkg::COORD_W-1:0]   s_box_left,
    input  logic signed [gbs_pkg::COORD_W-1:0]   s_box_top,
    input  logic [gbs_pkg::COORD_W-1:0]          s_box_width,
    input  logic [gbs_pkg::COORD_W-1:0]          s_box_height,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_keep,
    output logic [gbs_pkg::SLOT_W-1:0]           m_kept_slot,
    output logic                                 m_table_full
);

    localparam int CNT_W = $clog2(MAX_KEPT + 1);
    localparam int AW    = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_KEPT);

    gbs_pkg::state_t              state_reg, state_next;
    logic [CNT_W-1:0]             count_reg, count_next;
    logic [CNT_W-1:0]             idx_reg, idx_next;
    logic                         rd_valid_reg, rd_valid_next;
    logic                         suppress_reg, suppress_next;
    logic [gbs_pkg::THR_W-1:0]    thr_reg;
    gbs_pkg::box_t                cur_reg;
    logic                         m_valid_reg, m_valid_next;
    logic                         keep_reg, keep_next;
    logic [gbs_pkg::SLOT_W-1:0]   slot_reg, slot_next;
    logic                         full_reg, full_next;
    logic                         wr_en;
    logic [31:0]                  count_ext;
    logic [gbs_pkg::BOX_W-1:0]    rd_data;
    gbs_pkg::iou_status_t         iou_st;
    logic                         in_fire;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == gbs_pkg::ST_IDLE);
    assign in_fire   = s_valid && s_ready;
    assign count_ext = 32'(count_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= gbs_pkg::IOU_THR_RESET;
        end else if (cfg_valid && cfg_ready) begin
            thr_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            cur_reg <= '{left: s_box_left, top: s_box_top,
                         width: s_box_width, height: s_box_height};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= gbs_pkg::ST_IDLE;
            count_reg    <= '0;
            idx_reg      <= '0;
            rd_valid_reg <= 1'b0;
            suppress_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            idx_reg      <= idx_next;
            rd_valid_reg <= rd_valid_next;
            suppress_reg <= suppress_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        keep_reg <= keep_next;
        slot_reg <= slot_next;
        full_reg <= full_next;
    end

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        rd_valid_next = 1'b0;
        suppress_next = suppress_reg | (iou_st.hit_valid & iou_st.hit);
        m_valid_next  = m_valid_reg && !m_ready;
        keep_next     = keep_reg;
        slot_next     = slot_reg;
        full_next     = full_reg;
        wr_en         = 1'b0;
        case (state_reg)
            gbs_pkg::ST_IDLE: begin
                if (in_fire) begin
                    if (s_frame_start) begin
                        count_next = '0;
                    end
                    idx_next      = '0;
                    suppress_next = 1'b0;
                    state_next    = gbs_pkg::ST_SCAN;
                end
            end
            gbs_pkg::ST_SCAN: begin
                if (idx_reg == count_reg) begin
                    state_next = gbs_pkg::ST_DRAIN;
                end else begin
                    rd_valid_next = 1'b1;
                    idx_next      = idx_reg + 1'b1;
                end
            end
            gbs_pkg::ST_DRAIN: begin
                if (!rd_valid_reg && !iou_st.busy) begin
                    state_next = gbs_pkg::ST_FINISH;
                end
            end
            gbs_pkg::ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    keep_next    = !suppress_reg;
                    slot_next    = count_ext[gbs_pkg::SLOT_W-1:0];
                    full_next    = !suppress_reg && (count_reg == CNT_MAX);
                    if (!suppress_reg && (count_reg != CNT_MAX)) begin
                        wr_en      = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    state_next = gbs_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = gbs_pkg::ST_IDLE;
            end
        endcase
    end

    gbs_ram #(
        .WIDTH (gbs_pkg::BOX_W),
        .DEPTH (MAX_KEPT)
    ) u_box_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (cur_reg),
        .rd_addr (idx_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    gbs_iou u_iou (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .entry_valid (rd_valid_reg),
        .entry       (gbs_pkg::box_t'(rd_data)),
        .cur         (cur_reg),
        .thr         (thr_reg),
        .status      (iou_st)
    );

    assign m_valid      = m_valid_reg;
    assign m_keep       = keep_reg;
    assign m_kept_slot  = slot_reg;
    assign m_table_full = full_reg;

    a_idle_pipe_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (!rd_valid_reg && !iou_st.busy))
        else $error("item accepted while compare pipeline busy");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (count_reg < CNT_MAX))
        else $error("box write beyond table depth");

    a_frame_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && s_frame_start) |=> (count_reg == '0))
        else $error("frame start did not empty kept list");

    a_full_implies_keep: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_table_full) |-> m_keep)
        else $error("table full reported on suppressed box");

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for greedy_box_suppression_core.
// A directed table covers the corner cases of the overlap test. Random
// clustered frames, full-table frames and noise follow, run under three
// flow-control profiles. Every result is checked against an in-bench
// suppression model, or for typed directed rows against the table's verdict.
// ----------------------------------------------------------------------------
module tb;

    localparam int COORD_W = gbs_pkg::COORD_W;
    localparam int THR_W   = gbs_pkg::THR_W;
    localparam int SLOT_W  = gbs_pkg::SLOT_W;
    localparam logic [THR_W-1:0] IOU_THR_RESET = gbs_pkg::IOU_THR_RESET;

    typedef gbs_pkg::box_t box_t;
    typedef longint unsigned u64_t;

    localparam int KEPT_DEPTH      = gbs_pkg::MAX_KEPT_DEF;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int ITEMS_PER_PHASE = 300;
    localparam int MAX_SHOWN       = 10;

    typedef struct packed {
        logic              keep;
        logic [SLOT_W-1:0] slot;
        logic              full;
    } verdict_t;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_BOX,
        ROW_BOX_TYPED
    } row_kind_t;

    typedef struct packed {
        row_kind_t        kind;
        logic [THR_W-1:0] thr;
        logic             frame_start;
        box_t             box;
        verdict_t         verdict;
    } stim_row_t;

    localparam verdict_t V_NONE = '{1'b0, 7'd0, 1'b0};

    localparam stim_row_t DIRECTED [22] = '{
        '{ROW_BOX_TYPED, 8'd0, 1'b1, '{16'sd0, 16'sd0, 16'd160, 16'd160}, '{1'b1, 7'd0, 1'b0}},
        '{ROW_BOX_TYPED, 8'd0, 1'b0, '{16'sd0, 16'sd0, 16'd160, 16'd160}, '{1'b0, 7'd1, 1'b0}},
        '{ROW_BOX_TYPED, 8'd0, 1'b0, '{16'sd160, 16'sd0, 16'd160, 16'd160}, '{1'b1, 7'd1, 1'b0}},
        '{ROW_BOX_TYPED, 8'd0, 1'b0, '{16'sh8000, 16'sh8000, 16'd16, 16'd16}, '{1'b1, 7'd2, 1'b0}},
        '{ROW_BOX_TYPED, 8'd0, 1'b0, '{16'sd0, 16'sd0, 16'd0, 16'd0}, '{1'b1, 7'd3, 1'b0}},
        '{ROW_BOX_TYPED, 8'd0, 1'b0, '{16'sd0, 16'sd0, 16'd0, 16'd0}, '{1'b1, 7'd4, 1'b0}},
        '{ROW_BOX_TYPED, 8'd0, 1'b0, '{16'sd32767, 16'sd32767, 16'd65535, 16'd65535},
          '{1'b1, 7'd5, 1'b0}},
        '{ROW_BOX, 8'd0, 1'b0, '{16'sh8000, 16'sh8000, 16'd65535, 16'd65535}, V_NONE},
        '{ROW_BOX, 8'd0, 1'b0, '{16'sd80, 16'sd0, 16'd160, 16'd160}, V_NONE},
        '{ROW_CFG, 8'd0, 1'b0, '{16'sd0, 16'sd0, 16'd0, 16'd0}, V_NONE},
        '{ROW_BOX_TYPED, 8'd0, 1'b1, '{16'sd0, 16'sd0, 16'd160, 16'd160}, '{1'b1, 7'd0, 1'b0}},
        '{ROW_BOX_TYPED, 8'd0, 1'b0, '{16'sd159, 16'sd159, 16'd160, 16'd160},
          '{1'b0, 7'd1, 1'b0}},
        '{ROW_BOX_TYPED, 8'd0, 1'b0, '{16'sd160, 16'sd160, 16'd16, 16'd16}, '{1'b1, 7'd1, 1'b0}},
        '{ROW_CFG, 8'd255, 1'b0, '{16'sd0, 16'sd0, 16'd0, 16'd0}, V_NONE},
        '{ROW_BOX_TYPED, 8'd0, 1'b1, '{16'sd100, -16'sd200, 16'd300, 16'd50},
          '{1'b1, 7'd0, 1'b0}},
        '{ROW_BOX_TYPED, 8'd0, 1'b0, '{16'sd100, -16'sd200, 16'd300, 16'd50},
          '{1'b0, 7'd1, 1'b0}},
        '{ROW_BOX, 8'd0, 1'b0, '{16'sd101, -16'sd200, 16'd299, 16'd50}, V_NONE},
        '{ROW_BOX, 8'd0, 1'b0, '{16'sd32767, 16'sh8000, 16'd65535, 16'd0}, V_NONE},
        '{ROW_CFG, 8'd102, 1'b0, '{16'sd0, 16'sd0, 16'd0, 16'd0}, V_NONE},
        '{ROW_BOX_TYPED, 8'd0, 1'b1, '{-16'sd1, -16'sd1, 16'd65535, 16'd65535},
          '{1'b1, 7'd0, 1'b0}},
        '{ROW_BOX, 8'd0, 1'b0, '{16'sh8000, 16'sh8000, 16'd65535, 16'd65535}, V_NONE},
        '{ROW_BOX_TYPED, 8'd0, 1'b1, '{16'sd0, 16'sd0, 16'd65535, 16'd65535},
          '{1'b1, 7'd0, 1'b0}}
    };

    logic                      aclk          = 1'b0;
    logic                      aresetn       = 1'b0;
    logic                      cfg_valid     = 1'b0;
    logic                      cfg_ready;
    logic [THR_W-1:0]          cfg_data      = IOU_THR_RESET;
    logic                      s_valid       = 1'b0;
    logic                      s_ready;
    logic                      s_frame_start = 1'b0;
    logic signed [COORD_W-1:0] s_box_left    = '0;
    logic signed [COORD_W-1:0] s_box_top     = '0;
    logic [COORD_W-1:0]        s_box_width   = '0;
    logic [COORD_W-1:0]        s_box_height  = '0;
    logic                      m_valid;
    logic                      m_ready       = 1'b0;
    logic                      m_keep;
    logic [SLOT_W-1:0]         m_kept_slot;
    logic                      m_table_full;

    box_t             stored_boxes [KEPT_DEPTH];
    int unsigned      stored_count = 0;
    logic [THR_W-1:0] iou_thr      = IOU_THR_RESET;
    verdict_t         pending_verdicts [$];

    int send_idle_pct = 12;
    int recv_idle_pct = 84;
    int idle_cycles   = 0;
    int items_sent    = 0;
    int results_seen  = 0;
    int mismatches    = 0;
    int n_kept        = 0;
    int n_suppressed  = 0;
    int n_full        = 0;
    int thr_writes    = 0;

    always #10 aclk = ~aclk;

    greedy_box_suppression_core #(
        .MAX_KEPT(KEPT_DEPTH)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_frame_start(s_frame_start),
        .s_box_left   (s_box_left),
        .s_box_top    (s_box_top),
        .s_box_width  (s_box_width),
        .s_box_height (s_box_height),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_keep       (m_keep),
        .m_kept_slot  (m_kept_slot),
        .m_table_full (m_table_full)
    );

    function automatic u64_t span_overlap(longint a0, u64_t alen, longint b0, u64_t blen);
        longint a1, b1, lo, hi;
        a1 = a0 + longint'(alen);
        b1 = b0 + longint'(blen);
        lo = (a0 > b0) ? a0 : b0;
        hi = (a1 < b1) ? a1 : b1;
        return (hi > lo) ? u64_t'(hi - lo) : 64'd0;
    endfunction

    function automatic bit overlaps_too_much(box_t a, box_t b, logic [THR_W-1:0] thr);
        u64_t inter, area_a, area_b, uni;
        inter  = span_overlap($signed(a.left), a.width, $signed(b.left), b.width) *
                 span_overlap($signed(a.top), a.height, $signed(b.top), b.height);
        area_a = u64_t'(a.width) * u64_t'(a.height);
        area_b = u64_t'(b.width) * u64_t'(b.height);
        uni    = area_a + area_b - inter;
        return (inter << 8) > (u64_t'(thr) * uni);
    endfunction

    function automatic verdict_t judge_box(logic frame_start, box_t b);
        verdict_t v;
        bit       keep;
        if (frame_start) stored_count = 0;
        keep = 1'b1;
        for (int j = 0; j < stored_count; j++) begin
            if (overlaps_too_much(b, stored_boxes[j], iou_thr)) keep = 1'b0;
        end
        v.keep = keep;
        v.slot = SLOT_W'(stored_count);
        v.full = 1'b0;
        if (keep) begin
            if (stored_count < KEPT_DEPTH) begin
                stored_boxes[stored_count] = b;
                stored_count++;
            end else begin
                v.full = 1'b1;
            end
        end
        return v;
    endfunction

    task automatic send_box(input logic fs, input box_t b, input bit typed,
                            input verdict_t typed_v);
        verdict_t v;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_frame_start <= fs;
        s_box_left    <= b.left;
        s_box_top     <= b.top;
        s_box_width   <= b.width;
        s_box_height  <= b.height;
        do @(posedge aclk); while (!s_ready);
        v = judge_box(fs, b);
        if (typed) v = typed_v;
        pending_verdicts = {pending_verdicts, v};
        items_sent++;
        if (!v.keep) n_suppressed++;
        else if (v.full) n_full++;
        else n_kept++;
    endtask

    // hold the sender until the last result is out; polled off the active edge
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending_verdicts.size() != 0);
        @(posedge aclk);
    endtask

    task automatic write_threshold(input logic [THR_W-1:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        iou_thr = value;
        thr_writes++;
    endtask

    // boxes scattered around one center, with repeats, so overlaps are common
    task automatic run_cluster_frame();
        int   n, cx, cy, sp;
        box_t b, prev;
        n  = $urandom_range(1, 20);
        cx = $urandom_range(0, 8000) - 4000;
        cy = $urandom_range(0, 8000) - 4000;
        sp = $urandom_range(0, 200);
        prev = '0;
        for (int i = 0; i < n; i++) begin
            if (i > 0 && $urandom_range(7) == 0) begin
                b = prev;
            end else begin
                b.width  = COORD_W'($urandom_range(0, 480));
                b.height = COORD_W'($urandom_range(0, 480));
                b.left   = COORD_W'(cx + $urandom_range(0, 2 * sp) - sp);
                b.top    = COORD_W'(cy + $urandom_range(0, 2 * sp) - sp);
            end
            send_box(i == 0, b, 1'b0, V_NONE);
            prev = b;
        end
    endtask

    // disjoint grid fills the store, then far boxes hit the limit and repeats are suppressed
    task automatic run_full_frame();
        box_t b;
        int   n_extra;
        for (int i = 0; i < KEPT_DEPTH; i++) begin
            b.left   = COORD_W'(-16000 + (i % 16) * 256 + $urandom_range(0, 40));
            b.top    = COORD_W'(-16000 + (i / 16) * 256 + $urandom_range(0, 40));
            b.width  = COORD_W'($urandom_range(1, 200));
            b.height = COORD_W'($urandom_range(1, 200));
            send_box(i == 0, b, 1'b0, V_NONE);
        end
        n_extra = $urandom_range(1, 6);
        for (int i = 0; i < n_extra; i++) begin
            if ($urandom_range(1) == 1) begin
                b = stored_boxes[$urandom_range(0, KEPT_DEPTH - 1)];
            end else begin
                b.left   = COORD_W'(20000 + $urandom_range(0, 5000));
                b.top    = COORD_W'(20000 + $urandom_range(0, 5000));
                b.width  = COORD_W'($urandom_range(0, 300));
                b.height = COORD_W'($urandom_range(0, 300));
            end
            send_box(1'b0, b, 1'b0, V_NONE);
        end
    endtask

    task automatic run_noise();
        int   n;
        box_t b;
        n = $urandom_range(1, 5);
        for (int i = 0; i < n; i++) begin
            b = box_t'({$urandom, $urandom});
            send_box($urandom_range(3) == 0, b, 1'b0, V_NONE);
        end
    endtask

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        verdict_t exp_v, got_v;
        if (aresetn && m_valid && m_ready) begin
            got_v = '{m_keep, m_kept_slot, m_table_full};
            results_seen++;
            if (pending_verdicts.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("unexpected result: keep=%0d slot=%0d full=%0d",
                             got_v.keep, got_v.slot, got_v.full);
            end else begin
                exp_v = pending_verdicts.pop_front();
                if (got_v !== exp_v) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display({"result %0d: expected keep=%0d slot=%0d full=%0d,",
                                  " got keep=%0d slot=%0d full=%0d"},
                                 results_seen, exp_v.keep, exp_v.slot, exp_v.full,
                                 got_v.keep, got_v.slot, got_v.full);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", idle_cycles);
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int pick;
        int phase_start;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < $size(DIRECTED); r++) begin
            if (DIRECTED[r].kind == ROW_CFG)
                write_threshold(DIRECTED[r].thr);
            else
                send_box(DIRECTED[r].frame_start, DIRECTED[r].box,
                         DIRECTED[r].kind == ROW_BOX_TYPED, DIRECTED[r].verdict);
        end

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 12;
                    recv_idle_pct = 84;
                end
                1: begin
                    send_idle_pct = 84;
                    recv_idle_pct = 12;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            write_threshold(THR_W'($urandom_range(0, 255)));
            phase_start = items_sent;
            run_full_frame();
            while (items_sent - phase_start < ITEMS_PER_PHASE) begin
                pick = $urandom_range(99);
                if (pick < 4) wait_drained();
                else if (pick < 7) write_threshold(THR_W'($urandom_range(0, 255)));
                else if (pick < 10) run_full_frame();
                else if (pick < 80) run_cluster_frame();
                else run_noise();
            end
        end

        wait_drained();
        repeat (KEPT_DEPTH + 16) @(posedge aclk);
        if (pending_verdicts.size() != 0) begin
            $display("%0d results never arrived", pending_verdicts.size());
            mismatches += pending_verdicts.size();
        end

        $display("%0d boxes sent: %0d kept, %0d suppressed, %0d kept past a full store",
                 items_sent, n_kept, n_suppressed, n_full);
        $display("%0d results checked over %0d threshold writes, %0d mismatches",
                 results_seen, thr_writes, mismatches);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
